### rtl/rau_pkg.sv
// Types, codes and the fixed field widths shared by the rational unit
package rau_pkg;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_EQ  = 4'd4,
    MODE_NE  = 4'd5,
    MODE_LT  = 4'd6,
    MODE_GT  = 4'd7,
    MODE_LE  = 4'd8,
    MODE_GE  = 4'd9
  } mode_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               truth;
    logic               error;
  } out_item_t;

  // Classified job passed from the front end to the reduction engine
  typedef struct packed {
    logic        direct;    // result already final, no reduction needed
    logic        neg;       // sign of the numerator to reduce
    logic [63:0] mag;       // numerator magnitude
    logic [63:0] den;       // positive denominator
    out_item_t   res;       // result when direct
  } job_t;

endpackage

### rtl/rau_front.sv
// Front end, two stages: sign-extends operands and forms cross-products, then sums, compares and classifies
module rau_front import rau_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_stall,
  output job_t     job
);

  localparam int DW = NUM_WIDTH - 1;

  // stage 1: operands and products
  logic               s1_v_r;
  logic [3:0]         s1_mode_r;
  logic               s1_bad_r;
  logic signed [63:0] lhs_r, rhs_r, nn_r, dd_r;

  logic signed [63:0] an, bn, ad, bd;
  logic               bad;

  always_comb begin
    an = 64'(signed'(in_data.a_num[NUM_WIDTH-1:0]));
    bn = 64'(signed'(in_data.b_num[NUM_WIDTH-1:0]));
    ad = 64'(in_data.a_den[DW-1:0]);
    bd = 64'(in_data.b_den[DW-1:0]);
    bad = (in_data.mode > MODE_GE) || (ad == 64'sd0) || (bd == 64'sd0) ||
          ((in_data.mode == MODE_DIV) && (bn == 64'sd0));
  end

  logic s1_adv;
  assign s1_adv   = !s1_v_r || !job_valid || !job_stall;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_mode_r <= in_data.mode;
      s1_bad_r  <= bad;
      lhs_r     <= an * bd;
      rhs_r     <= bn * ad;
      nn_r      <= an * bn;
      dd_r      <= ad * bd;
    end
  end

  // stage 2: sums, compares, classification
  job_t               job_r, job_nxt;
  logic               job_v_r;
  logic signed [63:0] num;
  logic [63:0]        den;
  logic               t;

  always_comb begin
    num = 64'sd0;
    den = 64'd1;
    t   = 1'b0;
    job_nxt = '0;
    unique case (s1_mode_r)
      MODE_ADD: begin num = lhs_r + rhs_r; den = dd_r; end
      MODE_SUB: begin num = lhs_r - rhs_r; den = dd_r; end
      MODE_MUL: begin num = nn_r; den = dd_r; end
      MODE_DIV: begin
        num = rhs_r[63] ? -lhs_r : lhs_r;
        den = rhs_r[63] ? -rhs_r : rhs_r;
      end
      MODE_EQ:  t = lhs_r == rhs_r;
      MODE_NE:  t = lhs_r != rhs_r;
      MODE_LT:  t = lhs_r < rhs_r;
      MODE_GT:  t = lhs_r > rhs_r;
      MODE_LE:  t = lhs_r <= rhs_r;
      default:  t = lhs_r >= rhs_r;
    endcase
    if (s1_bad_r) begin
      job_nxt.direct    = 1'b1;
      job_nxt.res.error = 1'b1;
    end else if (s1_mode_r >= MODE_EQ) begin
      job_nxt.direct    = 1'b1;
      job_nxt.res.truth = t;
    end else if (num == 64'sd0) begin
      job_nxt.direct      = 1'b1;
      job_nxt.res.res_den = 63'd1;
    end else begin
      job_nxt.neg = num[63];
      job_nxt.mag = num[63] ? -num : num;
      job_nxt.den = den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (!job_v_r || !job_stall) begin
      job_v_r <= s1_v_r;
    end
    if ((!job_v_r || !job_stall) && s1_v_r) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_v_r;
  assign job       = job_r;

endmodule

### rtl/rau_queue.sv
// Two-entry queue between the front end and the reduction engine
module rau_queue import rau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output job_t rd_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd && cnt_r == 2'd0))
    else $error("queue read when empty");
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid && rd_stall |=> rd_valid && $stable(rd_data))
    else $error("queue head changed while stalled");

endmodule

### rtl/rau_reduce.sv
// Back end: Euclidean GCD and divisions by it, one subtract-shift step per cycle
module rau_reduce import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_stall,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_DIVN, ST_DIVD, ST_OUT} st_t;

  st_t         st_r;
  logic        neg_r;
  logic [63:0] y_r, mag_r, den_r;
  logic [63:0] rem_r, quo_r, dvd_r;
  logic [6:0]  cnt_r;
  out_item_t   out_r;

  // restoring division step shared by the modulo and both quotients
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] rem_nxt;
  logic [63:0] quo_nxt;
  always_comb begin
    rem_sh  = {rem_r[62:0], dvd_r[63]};
    trial   = {1'b0, rem_sh} - {1'b0, y_r};
    rem_nxt = trial[64] ? rem_sh : trial[63:0];
    quo_nxt = {quo_r[62:0], !trial[64]};
  end

  assign job_stall = st_r != ST_IDLE;
  assign out_valid = st_r == ST_OUT;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: if (job_valid) begin
          if (job.direct) begin
            out_r <= job.res;
            st_r  <= ST_OUT;
          end else begin
            neg_r <= job.neg;
            mag_r <= job.mag;
            den_r <= job.den;
            y_r   <= job.den;
            dvd_r <= job.mag;
            rem_r <= '0;
            cnt_r <= 7'd0;
            st_r  <= ST_MOD;
          end
        end
        ST_MOD: begin
          // x mod y, then x <= y, y <= remainder
          if (cnt_r == 7'd63) begin
            rem_r <= '0;
            cnt_r <= 7'd0;
            if (rem_nxt == 64'd0) begin
              // gcd is y_r; divide numerator by it
              dvd_r <= mag_r;
              st_r  <= ST_DIVN;
            end else begin
              y_r   <= rem_nxt;
              dvd_r <= y_r;
            end
          end else begin
            dvd_r <= {dvd_r[62:0], 1'b0};
            rem_r <= rem_nxt;
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_DIVN, ST_DIVD: begin
          if (cnt_r == 7'd63) begin
            rem_r <= '0;
            cnt_r <= 7'd0;
            if (st_r == ST_DIVN) begin
              out_r.res_num <= neg_r ? -quo_nxt : quo_nxt;
              dvd_r <= den_r;
              st_r  <= ST_DIVD;
            end else begin
              out_r.res_den <= quo_nxt[62:0];
              out_r.truth   <= 1'b0;
              out_r.error   <= 1'b0;
              st_r          <= ST_OUT;
            end
          end else begin
            dvd_r <= {dvd_r[62:0], 1'b0};
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_OUT: if (!out_stall) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> job_stall)
    else $error("job taken while busy");
  a_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIVN |-> y_r != 64'd0)
    else $error("zero divisor");

endmodule

### rtl/rational_arithmetic_unit.sv
// Compare, error and zero results pass the front end, the queue and the back end's result
// register; reduced results first run Euclid's GCD and the divisions by it in the back end.
// Throughput: one item per reduction; the 64-step shift-subtract divider
// in the back end sets it. The front end and a 2-entry queue run ahead.
// Reset: synchronous, active low; clears all valid and state bits.
// Top level of the rational arithmetic unit
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  rau_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  rau_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job)
  );

  rau_reduce u_reduce (
    .clk, .rst_n,
    .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .out_data
  );

endmodule
